@@ rtl/lru_key_value_cache_defines.svh @@
// ----------------------------------------------------------------------------
// lru_key_value_cache_defines
// assertion macros shared by the lru key-value cache rtl
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// consequent checked in the same cycle
`define LRUK_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the next cycle
`define LRUK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/lruk_pkg.sv @@
// ----------------------------------------------------------------------------
// lruk_pkg
// shared widths, codes and types of the lru key-value cache
// ----------------------------------------------------------------------------
`default_nettype none

package lruk_pkg;

   localparam int KEY_W      = 32;
   localparam int VALUE_W    = 64;
   localparam int CFG_W      = 7;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CFG_W-1:0]      CAPACITY_RESET = 7'd64;
   localparam logic [CSR_ADDR_W-3:0] REG_CAPACITY   = 1'd0;

   typedef enum logic {
      OP_PUT = 1'b0,
      OP_GET = 1'b1
   } op_type;

   typedef struct packed {
      logic match_found;
      logic free_found;
      logic old_found;
   } scan_flags_type;

endpackage

`default_nettype wire

@@ rtl/lru_key_value_cache.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache
// fully associative key-value cache with least-recently-used replacement
//
// requests arrive on the req_ channel (valid/stall): a put stores req_value
// under req_key, a get looks req_key up. each request gives exactly one
// transfer on the rsp_ channel with hit, read_value and evicted.
// keys, ranks and valid marks live in a tag ram, values in a value ram. a
// request walks the whole tag ram one entry per cycle, aging the ranks left
// by the previous request while it searches, then the decide state writes the
// chosen entry; a get hit then reads the value ram, and the finish state loads
// the response register and raises rsp_valid. req_stall stays high from the
// request transfer until the block is back in idle, so a new request is taken
// only after the last one is through. after reset a clearing pass empties the
// tag ram, with req_stall high; the capacity register is writable during that pass.
// the response sits in an output register: while rsp_stall is high the next
// request still runs and its result waits until that register is taken.
// the capacity register sits at byte address 0 of the register port.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache
   import lruk_pkg::*;
#(
   parameter int ENTRIES = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_operation,
   input  logic signed [KEY_W-1:0] req_key,
   input  logic [VALUE_W-1:0]      req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_hit,
   output logic [VALUE_W-1:0]      rsp_read_value,
   output logic                    rsp_evicted,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CSR_ADDR_W-1:0]   paddr,
   input  logic [CSR_DATA_W-1:0]   pwdata,
   output logic [CSR_DATA_W-1:0]   prdata,
   output logic                    pready
);

   localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int PW    = $clog2(ENTRIES + 1);
   localparam int CW    = (PW > CFG_W) ? PW : CFG_W;
   localparam int REC_W = 1 + IW + KEY_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_VREAD,
      ST_FINISH
   } state_type;

   state_type           state_ff, state_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic                issue_ff, issue_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [IW-1:0]       rd_addr_ff, rd_addr_in;
   op_type              op_ff, op_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic                pend_active_ff, pend_active_in;
   logic [IW-1:0]       pend_idx_ff, pend_idx_in;
   logic [PW-1:0]       pend_rank_ff, pend_rank_in;
   logic [PW-1:0]       used_ff, used_in;
   logic                res_hit_ff, res_hit_in;
   logic [VALUE_W-1:0]  res_value_ff, res_value_in;
   logic                res_evicted_ff, res_evicted_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic [VALUE_W-1:0]  rsp_read_value_ff, rsp_read_value_in;
   logic                rsp_evicted_ff, rsp_evicted_in;
   logic [CFG_W-1:0]    cap_ff, cap_in;

   logic                csr_write;
   logic                csr_sel_cap;
   logic [CW-1:0]       eff_cap;
   logic                have_free;

   logic                tag_we;
   logic [IW-1:0]       tag_waddr;
   logic [REC_W-1:0]    tag_wdata;
   logic                tag_re;
   logic [IW-1:0]       tag_raddr;
   logic [REC_W-1:0]    tag_rdata;
   logic                val_we;
   logic [IW-1:0]       val_waddr;
   logic                val_re;
   logic [IW-1:0]       val_raddr;
   logic [VALUE_W-1:0]  val_rdata;

   logic                scan_start;
   logic [REC_W-1:0]    scan_wb_data;
   scan_flags_type      scan_flags;
   logic [IW-1:0]       match_idx;
   logic [IW-1:0]       match_rank;
   logic [IW-1:0]       free_idx;
   logic [IW-1:0]       old_idx;
   logic [IW-1:0]       old_rank;

   // configuration register
   assign csr_write   = psel && penable && pwrite && pready;
   assign csr_sel_cap = (paddr[CSR_ADDR_W-1:2] == REG_CAPACITY);
   assign pready      = 1'b1;
   assign prdata      = csr_sel_cap ? CSR_DATA_W'(cap_ff) : '0;
   assign cap_in      = (csr_write && csr_sel_cap) ? pwdata[CFG_W-1:0] : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAPACITY_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CW'(1);
      end else if (CW'(cap_ff) > CW'(ENTRIES)) begin
         eff_cap = CW'(ENTRIES);
      end else begin
         eff_cap = CW'(cap_ff);
      end
   end

   assign have_free = (CW'(used_ff) < eff_cap);

   lruk_ram #(
      .WIDTH (REC_W),
      .DEPTH (ENTRIES)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (tag_waddr),
      .wr_data (tag_wdata),
      .rd_en   (tag_re),
      .rd_addr (tag_raddr),
      .rd_data (tag_rdata)
   );

   lruk_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (ENTRIES)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_waddr),
      .wr_data (value_ff),
      .rd_en   (val_re),
      .rd_addr (val_raddr),
      .rd_data (val_rdata)
   );

   lruk_scan #(
      .ENTRIES (ENTRIES)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .start       (scan_start),
      .rec_valid   (rd_valid_ff),
      .rec_addr    (rd_addr_ff),
      .rec_data    (tag_rdata),
      .key         (key_ff),
      .pend_active (pend_active_ff),
      .pend_idx    (pend_idx_ff),
      .pend_rank   (pend_rank_ff),
      .wb_data     (scan_wb_data),
      .flags       (scan_flags),
      .match_idx   (match_idx),
      .match_rank  (match_rank),
      .free_idx    (free_idx),
      .old_idx     (old_idx),
      .old_rank    (old_rank)
   );

   always_comb begin
      state_in          = state_ff;
      idx_in            = idx_ff;
      issue_in          = issue_ff;
      rd_valid_in       = 1'b0;
      rd_addr_in        = idx_ff;
      op_in             = op_ff;
      key_in            = key_ff;
      value_in          = value_ff;
      pend_active_in    = pend_active_ff;
      pend_idx_in       = pend_idx_ff;
      pend_rank_in      = pend_rank_ff;
      used_in           = used_ff;
      res_hit_in        = res_hit_ff;
      res_value_in      = res_value_ff;
      res_evicted_in    = res_evicted_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_hit_in        = rsp_hit_ff;
      rsp_read_value_in = rsp_read_value_ff;
      rsp_evicted_in    = rsp_evicted_ff;
      tag_we            = 1'b0;
      tag_waddr         = idx_ff;
      tag_wdata         = '0;
      tag_re            = 1'b0;
      tag_raddr         = idx_ff;
      val_we            = 1'b0;
      val_waddr         = match_idx;
      val_re            = 1'b0;
      val_raddr         = match_idx;
      scan_start        = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            tag_we    = 1'b1;
            tag_waddr = idx_ff;
            tag_wdata = '0;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in      = op_type'(req_operation);
               key_in     = $unsigned(req_key);
               value_in   = req_value;
               idx_in     = '0;
               issue_in   = 1'b1;
               scan_start = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue_ff) begin
               tag_re      = 1'b1;
               tag_raddr   = idx_ff;
               rd_valid_in = 1'b1;
               rd_addr_in  = idx_ff;
               if (idx_ff == LAST_IDX) begin
                  issue_in = 1'b0;
               end else begin
                  idx_in = idx_ff + IW'(1);
               end
            end
            // aged rank goes back to the entry just read
            if (rd_valid_ff) begin
               tag_we    = 1'b1;
               tag_waddr = rd_addr_ff;
               tag_wdata = scan_wb_data;
               if (rd_addr_ff == LAST_IDX) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            res_hit_in     = 1'b0;
            res_value_in   = '0;
            res_evicted_in = 1'b0;
            pend_active_in = 1'b0;
            tag_wdata      = {1'b1, {IW{1'b0}}, key_ff};
            state_in       = ST_FINISH;
            if (op_ff == OP_GET) begin
               if (scan_flags.match_found) begin
                  res_hit_in     = 1'b1;
                  val_re         = 1'b1;
                  val_raddr      = match_idx;
                  tag_we         = 1'b1;
                  tag_waddr      = match_idx;
                  pend_active_in = 1'b1;
                  pend_idx_in    = match_idx;
                  pend_rank_in   = PW'(match_rank);
                  state_in       = ST_VREAD;
               end
            end else if (scan_flags.match_found) begin
               res_hit_in     = 1'b1;
               tag_we         = 1'b1;
               tag_waddr      = match_idx;
               val_we         = 1'b1;
               val_waddr      = match_idx;
               pend_active_in = 1'b1;
               pend_idx_in    = match_idx;
               pend_rank_in   = PW'(match_rank);
            end else if (have_free) begin
               tag_we         = 1'b1;
               tag_waddr      = free_idx;
               val_we         = 1'b1;
               val_waddr      = free_idx;
               pend_active_in = 1'b1;
               pend_idx_in    = free_idx;
               pend_rank_in   = PW'(ENTRIES);
               used_in        = used_ff + PW'(1);
            end else if (scan_flags.old_found) begin
               res_evicted_in = 1'b1;
               tag_we         = 1'b1;
               tag_waddr      = old_idx;
               val_we         = 1'b1;
               val_waddr      = old_idx;
               pend_active_in = 1'b1;
               pend_idx_in    = old_idx;
               pend_rank_in   = PW'(old_rank);
            end
         end
         ST_VREAD: begin
            res_value_in = val_rdata;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_hit_in        = res_hit_ff;
               rsp_read_value_in = res_value_ff;
               rsp_evicted_in    = res_evicted_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         idx_ff         <= '0;
         issue_ff       <= 1'b0;
         rd_valid_ff    <= 1'b0;
         pend_active_ff <= 1'b0;
         used_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         idx_ff         <= idx_in;
         issue_ff       <= issue_in;
         rd_valid_ff    <= rd_valid_in;
         pend_active_ff <= pend_active_in;
         used_ff        <= used_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rd_addr_ff        <= rd_addr_in;
      op_ff             <= op_in;
      key_ff            <= key_in;
      value_ff          <= value_in;
      pend_idx_ff       <= pend_idx_in;
      pend_rank_ff      <= pend_rank_in;
      res_hit_ff        <= res_hit_in;
      res_value_ff      <= res_value_in;
      res_evicted_ff    <= res_evicted_in;
      rsp_hit_ff        <= rsp_hit_in;
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_evicted_ff    <= rsp_evicted_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_evicted    = rsp_evicted_ff;

   `LRUK_ASSERT_NEXT(a_transfer_starts_scan, clock, reset, req_valid && !req_stall, state_ff == ST_SCAN, "request transfer did not start a scan")
   `LRUK_ASSERT_NOW(a_evict_only_on_put_miss, clock, reset, rsp_valid_ff && rsp_evicted_ff, !rsp_hit_ff && (rsp_read_value_ff == '0), "eviction reported with a hit or a value")
   `LRUK_ASSERT_NOW(a_victim_exists, clock, reset, (state_ff == ST_DECIDE) && (op_ff == OP_PUT) && !scan_flags.match_found && !have_free, scan_flags.old_found, "full cache without a victim entry")
   `LRUK_ASSERT_NOW(a_free_entry_exists, clock, reset, (state_ff == ST_DECIDE) && (op_ff == OP_PUT) && !scan_flags.match_found && have_free, scan_flags.free_found, "entry count below capacity without a free entry")

endmodule

`default_nettype wire

@@ rtl/lruk_ram.sv @@
// ----------------------------------------------------------------------------
// lruk_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module lruk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/lruk_scan.sv @@
// ----------------------------------------------------------------------------
// lruk_scan
// per-entry tag scan: ages ranks from the previous request and searches for
// the matching key, the first free entry and the least recent entry
// ----------------------------------------------------------------------------
`default_nettype none

module lruk_scan
   import lruk_pkg::*;
#(
   parameter int ENTRIES = 64
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           start,
   input  logic                                           rec_valid,
   input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rec_addr,
   input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)+KEY_W:0] rec_data,
   input  logic [KEY_W-1:0]                               key,
   input  logic                                           pend_active,
   input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] pend_idx,
   input  logic [$clog2(ENTRIES+1)-1:0]                   pend_rank,
   output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)+KEY_W:0] wb_data,
   output scan_flags_type                                 flags,
   output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] match_idx,
   output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] match_rank,
   output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] free_idx,
   output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] old_idx,
   output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] old_rank
);

   localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int PW    = $clog2(ENTRIES + 1);
   localparam int REC_W = 1 + IW + KEY_W;

   logic              e_valid;
   logic [IW-1:0]     e_rank;
   logic [KEY_W-1:0]  e_key;
   logic              aged;
   logic [IW-1:0]     adj_rank;

   scan_flags_type    flags_ff, flags_in;
   logic [IW-1:0]     match_idx_ff, match_idx_in;
   logic [IW-1:0]     match_rank_ff, match_rank_in;
   logic [IW-1:0]     free_idx_ff, free_idx_in;
   logic [IW-1:0]     old_idx_ff, old_idx_in;
   logic [IW-1:0]     old_rank_ff, old_rank_in;

   assign e_valid = rec_data[REC_W-1];
   assign e_rank  = rec_data[REC_W-2 -: IW];
   assign e_key   = rec_data[KEY_W-1:0];

   // entries more recent than the last promoted one move one place older
   assign aged     = pend_active && e_valid && (rec_addr != pend_idx) &&
                     (PW'(e_rank) < pend_rank);
   assign adj_rank = aged ? (e_rank + IW'(1)) : e_rank;
   assign wb_data  = {e_valid, adj_rank, e_key};

   always_comb begin
      flags_in      = flags_ff;
      match_idx_in  = match_idx_ff;
      match_rank_in = match_rank_ff;
      free_idx_in   = free_idx_ff;
      old_idx_in    = old_idx_ff;
      old_rank_in   = old_rank_ff;
      if (start) begin
         flags_in = '0;
      end else if (rec_valid) begin
         if (e_valid && (e_key == key) && !flags_ff.match_found) begin
            flags_in.match_found = 1'b1;
            match_idx_in         = rec_addr;
            match_rank_in        = adj_rank;
         end
         if (!e_valid && !flags_ff.free_found) begin
            flags_in.free_found = 1'b1;
            free_idx_in         = rec_addr;
         end
         if (e_valid && (!flags_ff.old_found || (adj_rank > old_rank_ff))) begin
            flags_in.old_found = 1'b1;
            old_idx_in         = rec_addr;
            old_rank_in        = adj_rank;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
      match_idx_ff  <= match_idx_in;
      match_rank_ff <= match_rank_in;
      free_idx_ff   <= free_idx_in;
      old_idx_ff    <= old_idx_in;
      old_rank_ff   <= old_rank_in;
   end

   assign flags      = flags_ff;
   assign match_idx  = match_idx_ff;
   assign match_rank = match_rank_ff;
   assign free_idx   = free_idx_ff;
   assign old_idx    = old_idx_ff;
   assign old_rank   = old_rank_ff;

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the lru key-value cache
//
// a table of directed requests and capacity writes runs first, then random
// phases. each phase sets a new capacity and sends gets and puts drawn mostly
// from a small key pool, so hits, fills and evictions happen often. every
// accepted request runs through an in-bench copy of the cache that predicts
// hit, read_value and evicted; rsp transfers are checked in order. both sides
// idle and stall at random, with quiet stretches in between.
// ----------------------------------------------------------------------------
module tb_top;
   import lruk_pkg::*;

   localparam int ENTRIES        = 64;
   localparam int DRAIN_CYCLES   = ENTRIES + 8;
   localparam int WATCHDOG_LIMIT = 20 * (ENTRIES + 5);
   localparam logic [CSR_ADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};

   typedef struct packed {
      logic               hit;
      logic [VALUE_W-1:0] read_value;
      logic               evicted;
   } cache_reply_type;

   typedef enum logic {
      ROW_REQUEST  = 1'b0,
      ROW_CAPACITY = 1'b1
   } row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      op_type             op;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      logic [CFG_W-1:0]   capacity;
      logic               typed;
      cache_reply_type    reply;
   } directed_row_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic                    req_operation;
   logic signed [KEY_W-1:0] req_key;
   logic [VALUE_W-1:0]      req_value;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic                    rsp_hit;
   logic [VALUE_W-1:0]      rsp_read_value;
   logic                    rsp_evicted;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [CSR_ADDR_W-1:0]   paddr;
   logic [CSR_DATA_W-1:0]   pwdata;
   logic [CSR_DATA_W-1:0]   prdata;
   logic                    pready;

   // predictor state
   logic [KEY_W-1:0]   slot_key   [ENTRIES];
   logic [VALUE_W-1:0] slot_value [ENTRIES];
   logic               slot_live  [ENTRIES];
   int                 slot_rank  [ENTRIES];
   int                 live_count;
   logic [CFG_W-1:0]   model_capacity;

   cache_reply_type  expected_replies [$];
   logic [KEY_W-1:0] key_pool [$];
   int               failures = 0;
   int               sent_count;
   int               reply_count;
   int               idle_cycles = 0;

   directed_row_type directed_rows [25] = '{
      '{ROW_REQUEST,  OP_GET, 32'h0000_0000, 64'h0, 7'd0, 1'b1, '{1'b0, 64'h0, 1'b0}},
      '{ROW_REQUEST,  OP_PUT, 32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0, 1'b1,
        '{1'b0, 64'h0, 1'b0}},
      '{ROW_REQUEST,  OP_GET, 32'h8000_0000, 64'h0, 7'd0, 1'b1,
        '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0}},
      '{ROW_REQUEST,  OP_PUT, 32'h7FFF_FFFF, 64'h0, 7'd0, 1'b1, '{1'b0, 64'h0, 1'b0}},
      '{ROW_REQUEST,  OP_GET, 32'h7FFF_FFFF, 64'h0, 7'd0, 1'b1, '{1'b1, 64'h0, 1'b0}},
      '{ROW_REQUEST,  OP_PUT, 32'hFFFF_FFFF, 64'h5555_5555_5555_5555, 7'd0, 1'b1,
        '{1'b0, 64'h0, 1'b0}},
      '{ROW_REQUEST,  OP_PUT, 32'hFFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA, 7'd0, 1'b1,
        '{1'b1, 64'h0, 1'b0}},
      '{ROW_REQUEST,  OP_GET, 32'hFFFF_FFFF, 64'h0, 7'd0, 1'b0, '0},
      '{ROW_REQUEST,  OP_GET, 32'h0000_0001, 64'h0, 7'd0, 1'b0, '0},
      // zero capacity, below the entries in use
      '{ROW_CAPACITY, OP_PUT, 32'h0, 64'h0, 7'd0, 1'b0, '0},
      '{ROW_REQUEST,  OP_PUT, 32'h0000_0005, 64'h0123_4567_89AB_CDEF, 7'd0, 1'b0, '0},
      '{ROW_REQUEST,  OP_GET, 32'h8000_0000, 64'h0, 7'd0, 1'b0, '0},
      '{ROW_REQUEST,  OP_PUT, 32'h0000_0006, 64'hFEDC_BA98_7654_3210, 7'd0, 1'b0, '0},
      '{ROW_REQUEST,  OP_GET, 32'h0000_0005, 64'h0, 7'd0, 1'b0, '0},
      // saturating capacity
      '{ROW_CAPACITY, OP_PUT, 32'h0, 64'h0, 7'd127, 1'b0, '0},
      '{ROW_REQUEST,  OP_PUT, 32'h0000_0007, 64'h1111_2222_3333_4444, 7'd0, 1'b0, '0},
      '{ROW_REQUEST,  OP_PUT, 32'h0000_0008, 64'h5555_6666_7777_8888, 7'd0, 1'b0, '0},
      '{ROW_REQUEST,  OP_GET, 32'h7FFF_FFFF, 64'h0, 7'd0, 1'b0, '0},
      '{ROW_CAPACITY, OP_PUT, 32'h0, 64'h0, 7'd1, 1'b0, '0},
      '{ROW_REQUEST,  OP_PUT, 32'h0000_0009, 64'h9999_AAAA_BBBB_CCCC, 7'd0, 1'b0, '0},
      '{ROW_REQUEST,  OP_PUT, 32'h0000_0009, 64'hDDDD_EEEE_FFFF_0000, 7'd0, 1'b0, '0},
      '{ROW_REQUEST,  OP_GET, 32'h0000_0008, 64'h0, 7'd0, 1'b0, '0},
      '{ROW_CAPACITY, OP_PUT, 32'h0, 64'h0, 7'd3, 1'b0, '0},
      '{ROW_REQUEST,  OP_PUT, 32'h0000_000A, 64'h0F0F_0F0F_F0F0_F0F0, 7'd0, 1'b0, '0},
      '{ROW_REQUEST,  OP_GET, 32'h0000_0000, 64'h0, 7'd0, 1'b0, '0}
   };

   lru_key_value_cache #(
      .ENTRIES(ENTRIES)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_key        (req_key),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hit        (rsp_hit),
      .rsp_read_value (rsp_read_value),
      .rsp_evicted    (rsp_evicted),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void make_most_recent(int idx, int old_rank);
      int i;
      for (i = 0; i < ENTRIES; i++) begin
         if (slot_live[i] && i != idx && slot_rank[i] < old_rank) begin
            slot_rank[i]++;
         end
      end
      slot_rank[idx] = 0;
   endfunction

   function automatic cache_reply_type predict_access(op_type op, logic [KEY_W-1:0] key,
                                                      logic [VALUE_W-1:0] value);
      cache_reply_type reply;
      int i;
      int found;
      int slot;
      int oldest;
      int limit;
      reply  = '0;
      found  = -1;
      slot   = -1;
      oldest = -1;
      for (i = 0; i < ENTRIES; i++) begin
         if (found < 0 && slot_live[i] && slot_key[i] == key) begin
            found = i;
         end
      end
      if (found >= 0) begin
         reply.hit = 1'b1;
         if (op == OP_GET) begin
            reply.read_value = slot_value[found];
         end else begin
            slot_value[found] = value;
         end
         make_most_recent(found, slot_rank[found]);
         return reply;
      end
      if (op == OP_GET) begin
         return reply;
      end
      limit = (model_capacity == 0) ? 1 :
              (int'(model_capacity) > ENTRIES) ? ENTRIES : int'(model_capacity);
      if (live_count < limit) begin
         for (i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && !slot_live[i]) begin
               slot = i;
            end
         end
      end
      if (slot >= 0) begin
         slot_live[slot]  = 1'b1;
         slot_key[slot]   = key;
         slot_value[slot] = value;
         make_most_recent(slot, ENTRIES);
         live_count++;
         return reply;
      end
      for (i = 0; i < ENTRIES; i++) begin
         if (slot_live[i] && (slot < 0 || slot_rank[i] > oldest)) begin
            oldest = slot_rank[i];
            slot   = i;
         end
      end
      if (slot >= 0) begin
         slot_key[slot]   = key;
         slot_value[slot] = value;
         make_most_recent(slot, oldest);
         reply.evicted = 1'b1;
      end
      return reply;
   endfunction

   task automatic send_request(op_type op, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value,
                               logic typed, cache_reply_type typed_reply);
      int gap;
      cache_reply_type predicted;
      gap = (((sent_count / 48) % 4) == 3) ? 0 : int'($urandom_range(0, 16));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_key       <= key;
      req_value     <= value;
      do @(posedge clock); while (req_stall);
      predicted = predict_access(op, key, value);
      expected_replies.push_back(typed ? typed_reply : predicted);
      sent_count++;
   endtask

   // drop valid, let every outstanding transfer come back, then write capacity
   task automatic settle_and_write(logic [CFG_W-1:0] capacity);
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_replies.size() != 0);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CAPACITY_ADDR;
      pwdata  <= CSR_DATA_W'(capacity);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      model_capacity = capacity;
   endtask

   // stimulus
   initial begin
      logic [CFG_W-1:0] phase_caps [8];
      int phase;
      int eff;
      int pool_size;
      int items;
      int n;
      op_type op;
      logic [KEY_W-1:0] key;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_operation = 1'b0;
      req_key       = '0;
      req_value     = '0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      sent_count    = 0;
      live_count    = 0;
      model_capacity = CAPACITY_RESET;
      for (n = 0; n < ENTRIES; n++) begin
         slot_live[n]  = 1'b0;
         slot_rank[n]  = 0;
         slot_key[n]   = '0;
         slot_value[n] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CAPACITY) begin
            settle_and_write(directed_rows[r].capacity);
         end else begin
            send_request(directed_rows[r].op, directed_rows[r].key, directed_rows[r].value,
                         directed_rows[r].typed, directed_rows[r].reply);
         end
      end

      phase_caps = '{7'd127, 7'd2, 7'd0, 7'd64, 7'd1, 7'd5,
                     CFG_W'($urandom_range(0, 127)), 7'd64};
      for (phase = 0; phase < 8; phase++) begin
         settle_and_write(phase_caps[phase]);
         eff = (phase_caps[phase] == 0) ? 1 :
               (int'(phase_caps[phase]) > ENTRIES) ? ENTRIES : int'(phase_caps[phase]);
         pool_size = eff + int'($urandom_range(1, eff / 2 + 3));
         key_pool.delete();
         for (n = 0; n < pool_size; n++) begin
            if ($urandom_range(0, 3) == 0) begin
               key_pool.push_back(KEY_W'(int'($urandom_range(0, 15)) - 8));
            end else begin
               key_pool.push_back($urandom);
            end
         end
         items = (eff >= 32) ? 70 : 30;
         for (n = 0; n < items; n++) begin
            op  = ($urandom_range(0, 99) < 55) ? OP_PUT : OP_GET;
            key = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom) :
                  key_pool[$urandom_range(0, key_pool.size() - 1)];
            send_request(op, key, {$urandom, $urandom}, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (expected_replies.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // result side
   initial begin
      int hold;
      cache_reply_type want;
      rsp_stall   = 1'b0;
      reply_count = 0;
      forever begin
         hold = (((reply_count / 48) % 4) == 1) ? 0 : int'($urandom_range(0, 16));
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         reply_count++;
         if (expected_replies.size() == 0) begin
            $error("rsp transfer with no request outstanding");
            failures++;
         end else begin
            want = expected_replies.pop_front();
            if (rsp_hit !== want.hit) begin
               $error("hit: expected %0b, got %0b", want.hit, rsp_hit);
               failures++;
            end
            if (rsp_read_value !== want.read_value) begin
               $error("read_value: expected %h, got %h", want.read_value, rsp_read_value);
               failures++;
            end
            if (rsp_evicted !== want.evicted) begin
               $error("evicted: expected %0b, got %0b", want.evicted, rsp_evicted);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
